// ===== sv/sta_pkg.sv =====
// ----------------------------------------------------------------------------
// sta_pkg: shared types and constants for the sorted term accumulator
// Field widths, result status codes, sequencer states and the arithmetic
// unit's result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package sta_pkg;

  localparam int COEF_W = 32;
  localparam int EXP_W  = 16;
  localparam int ENT_W  = COEF_W + EXP_W;

  typedef enum logic [2:0] {
    ST_MERGED     = 3'd0,
    ST_INSERTED   = 3'd1,
    ST_CANCELLED  = 3'd2,
    ST_FULL       = 3'd3,
    ST_DUMP_TERM  = 3'd4,
    ST_DUMP_EMPTY = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_INS,
    S_INS_WR,
    S_DEL,
    S_DUMP,
    S_RES
  } state_t;

  typedef struct packed {
    logic              eq;    // new exponent equals the stored one
    logic              gt;    // new exponent above the stored one
    logic [COEF_W-1:0] sum;   // clipped sum of coefficients
    logic              sat;   // sum was clipped
    logic              zero;  // sum is zero
  } alu_res_t;

endpackage

`default_nettype wire

// ===== sv/sta_ram.sv =====
// ----------------------------------------------------------------------------
// sta_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on a
// same-address collision).
// ----------------------------------------------------------------------------
`default_nettype none

module sta_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/sta_alu.sv =====
// ----------------------------------------------------------------------------
// sta_alu: shared compare and add unit
// Compares the incoming exponent with one stored term and forms the
// saturated sum of the two coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module sta_alu
  import sta_pkg::*;
(
  input  wire logic [COEF_W-1:0] coef,
  input  wire logic [EXP_W-1:0]  exp_in,
  input  wire logic [COEF_W-1:0] ent_coef,
  input  wire logic [EXP_W-1:0]  ent_exp,
  output alu_res_t               res
);

  logic signed [COEF_W:0] sum_w;
  logic                   ovf;

  assign sum_w = $signed({coef[COEF_W-1], coef}) + $signed({ent_coef[COEF_W-1], ent_coef});
  assign ovf   = sum_w[COEF_W] ^ sum_w[COEF_W-1];

  always_comb begin
    res.eq   = (exp_in == ent_exp);
    res.gt   = ($signed(exp_in) > $signed(ent_exp));
    res.sat  = ovf;
    res.zero = (sum_w == '0);
    if (ovf) begin
      // sign of the true sum picks the rail
      res.sum = sum_w[COEF_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      res.sum = sum_w[COEF_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/sorted_term_accumulator.sv =====
// ----------------------------------------------------------------------------
// sorted_term_accumulator: sparse polynomial term table
// Holds up to MAX_TERMS (coefficient, exponent) terms in a RAM, sorted by
// descending exponent, and merges, inserts, removes or dumps them.
//
// Usage:
//   in_*  : one beat per item. in_tuser is the kind (0 add, 1 dump),
//           in_tdata carries the term to add.
//   out_* : one beat per add, one beat per stored term on a dump (one beat
//           marked empty if the table is empty); out_tlast marks the final
//           beat of each item.
//   An add scans the table one entry a cycle through a single compare/add
//   unit, then shifts entries one a cycle through the one RAM write port;
//   the entries passed plus the entries moved never exceed MAX_TERMS.
//   The next item is taken only once the sequencer is back in idle.
//   in_tready is high only while the sequencer is idle; a finished result
//   may still wait in the output register meanwhile.
//   A stalled receiver holds the dump scan or the pending result until the
//   output register frees.
//   Reset empties the table (term count to zero) at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_term_accumulator
  import sta_pkg::*;
#(
  parameter int MAX_TERMS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [31:0] term_coef, [47:32] term_exp
  input  wire logic        in_tuser,   // [0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [31:0] out_coef, [47:32] out_exp
  output logic [3:0]       out_tuser,  // [2:0] status, [3] saturated
  output logic             out_tlast
);

  localparam int AW = $clog2(MAX_TERMS);
  localparam int CW = $clog2(MAX_TERMS + 1);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [COEF_W-1:0] coef_r, coef_nxt;
  logic [EXP_W-1:0]  exp_r, exp_nxt;

  status_t           res_status_r, res_status_nxt;
  logic [COEF_W-1:0] res_coef_r, res_coef_nxt;
  logic [EXP_W-1:0]  res_exp_r, res_exp_nxt;
  logic              res_sat_r, res_sat_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [COEF_W-1:0] out_coef_r, out_coef_nxt;
  logic [EXP_W-1:0]  out_exp_r, out_exp_nxt;
  logic              out_sat_r, out_sat_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;
  alu_res_t          alu;

  logic              slot_free;
  logic              at_last;
  logic              full;

  sta_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_TERMS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_nxt),
    .rdata(ram_rdata)
  );

  sta_alu u_alu (
    .coef    (coef_r),
    .exp_in  (exp_r),
    .ent_coef(ram_rdata[COEF_W-1:0]),
    .ent_exp (ram_rdata[ENT_W-1:COEF_W]),
    .res     (alu)
  );

  // read data always belongs to idx_r: the read address is idx_nxt
  assign slot_free = !out_valid_r || out_tready;
  assign at_last   = (CW'(idx_r) == count_r - CW'(1));
  assign full      = (count_r == CW'(MAX_TERMS));
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    coef_nxt       = coef_r;
    exp_nxt        = exp_r;
    res_status_nxt = res_status_r;
    res_coef_nxt   = res_coef_r;
    res_exp_nxt    = res_exp_r;
    res_sat_nxt    = res_sat_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_coef_nxt   = out_coef_r;
    out_exp_nxt    = out_exp_r;
    out_sat_nxt    = out_sat_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = ram_rdata;

    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_tvalid) begin
          coef_nxt = in_tdata[COEF_W-1:0];
          exp_nxt  = in_tdata[ENT_W-1:COEF_W];
          if (in_tuser) begin
            if (count_r == '0) begin
              res_status_nxt = ST_DUMP_EMPTY;
              res_coef_nxt   = '0;
              res_exp_nxt    = '0;
              res_sat_nxt    = 1'b0;
              state_nxt      = S_RES;
            end else begin
              state_nxt = S_DUMP;
            end
          end else if (count_r == '0) begin
            pos_nxt   = '0;
            state_nxt = S_INS_WR;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end

      S_SRCH: begin
        if (alu.eq) begin
          if (alu.zero) begin
            res_status_nxt = ST_CANCELLED;
            res_coef_nxt   = '0;
            res_exp_nxt    = exp_r;
            res_sat_nxt    = 1'b0;
            if (at_last) begin
              count_nxt = count_r - CW'(1);
              state_nxt = S_RES;
            end else begin
              idx_nxt   = idx_r + AW'(1);
              state_nxt = S_DEL;
            end
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = idx_r;
            ram_wdata      = {exp_r, alu.sum};
            res_status_nxt = ST_MERGED;
            res_coef_nxt   = alu.sum;
            res_exp_nxt    = exp_r;
            res_sat_nxt    = alu.sat;
            state_nxt      = S_RES;
          end
        end else if (alu.gt || at_last) begin
          if (full) begin
            res_status_nxt = ST_FULL;
            res_coef_nxt   = coef_r;
            res_exp_nxt    = exp_r;
            res_sat_nxt    = 1'b0;
            state_nxt      = S_RES;
          end else if (alu.gt) begin
            // open a slot at idx_r by moving the tail up, from the end
            pos_nxt   = idx_r;
            idx_nxt   = AW'(count_r - CW'(1));
            state_nxt = S_INS;
          end else begin
            pos_nxt   = count_r[AW-1:0];
            state_nxt = S_INS_WR;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + AW'(1);
        ram_wdata = ram_rdata;
        if (idx_r == pos_r) begin
          state_nxt = S_INS_WR;
        end else begin
          idx_nxt = idx_r - AW'(1);
        end
      end

      S_INS_WR: begin
        ram_we         = 1'b1;
        ram_waddr      = pos_r;
        ram_wdata      = {exp_r, coef_r};
        count_nxt      = count_r + CW'(1);
        res_status_nxt = ST_INSERTED;
        res_coef_nxt   = coef_r;
        res_exp_nxt    = exp_r;
        res_sat_nxt    = 1'b0;
        idx_nxt        = '0;
        state_nxt      = S_RES;
      end

      S_DEL: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r - AW'(1);
        ram_wdata = ram_rdata;
        if (at_last) begin
          count_nxt = count_r - CW'(1);
          idx_nxt   = '0;
          state_nxt = S_RES;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_DUMP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DUMP_TERM;
          out_coef_nxt   = ram_rdata[COEF_W-1:0];
          out_exp_nxt    = ram_rdata[ENT_W-1:COEF_W];
          out_sat_nxt    = 1'b0;
          out_last_nxt   = at_last;
          if (at_last) begin
            idx_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end

      S_RES: begin
        idx_nxt = '0;
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_coef_nxt   = res_coef_r;
          out_exp_nxt    = res_exp_r;
          out_sat_nxt    = res_sat_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    coef_r       <= coef_nxt;
    exp_r        <= exp_nxt;
    res_status_r <= res_status_nxt;
    res_coef_r   <= res_coef_nxt;
    res_exp_r    <= res_exp_nxt;
    res_sat_r    <= res_sat_nxt;
    out_status_r <= out_status_nxt;
    out_coef_r   <= out_coef_nxt;
    out_exp_r    <= out_exp_nxt;
    out_sat_r    <= out_sat_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_exp_r, out_coef_r};
  assign out_tuser  = {out_sat_r, out_status_r};
  assign out_tlast  = out_last_r;

  // table never overflows
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TERMS))
    else $error("term count above table size");

  // count moves by one at most
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CW'(1) || count_r == $past(count_r) - CW'(1)))
    else $error("term count jumped");

  // the insert write grows the table by one
  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_WR) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow table");

  // dump scan stays inside the filled part
  a_dump_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (CW'(idx_r) < count_r))
    else $error("dump index past term count");

endmodule

`default_nettype wire
